@@ hdl/lmbc_pkg.sv @@
package lmbc_pkg;

    localparam int FRAC_BITS       = 15;
    localparam int ONE             = 1 << FRAC_BITS;
    localparam int HALF            = 1 << (FRAC_BITS - 1);
    localparam int ACC_BITS        = FRAC_BITS + 9;
    localparam int DEF_MAX_LAYERS  = 16;

    // multiplier operand / product / sum widths
    localparam int A_W  = ACC_BITS + 3;
    localparam int B_W  = FRAC_BITS + 3;
    localparam int P_W  = A_W + B_W;
    localparam int S_W  = ACC_BITS + 8;
    localparam int T_W  = ACC_BITS + 1;

    localparam logic signed [S_W-1:0] ACC_MAX = S_W'((64'sd1 <<< (ACC_BITS - 1)) - 64'sd1);

    typedef enum logic [1:0] {
        ACT_BEGIN   = 2'd0,
        ACT_ADD     = 2'd1,
        ACT_COMPOSE = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        MODE_COPY     = 3'd0,
        MODE_ADD      = 3'd1,
        MODE_SUBTRACT = 3'd2,
        MODE_MULTIPLY = 3'd3,
        MODE_OVERLAY  = 3'd4,
        MODE_SCREEN   = 3'd5,
        MODE_LINEAR   = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        CFG_FILTER_RED   = 2'd0,
        CFG_FILTER_GREEN = 2'd1,
        CFG_FILTER_BLUE  = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHAN,
        ST_READ,
        ST_CHECK,
        ST_MUL0,
        ST_UPD0,
        ST_MUL1,
        ST_UPD1,
        ST_STAGE_END,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] base_red;
        logic [15:0] base_green;
        logic [15:0] base_blue;
        logic [15:0] base_alpha;
        logic [15:0] committed_red;
        logic [15:0] committed_green;
        logic [15:0] committed_blue;
        logic [15:0] mask_value;
        logic [15:0] layer_opacity;
        logic [2:0]  blend_mode;
    } t_in_word;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [15:0] out_alpha;
        logic        any_contributed;
        logic        status;
    } t_out_word;

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] opacity;
        logic [2:0]  mode;
    } t_layer;

    typedef struct packed {
        logic       load_vertex;
        logic       wr_en;
        logic       init_acc;
        logic       mul_en;
        logic       upd_en;
        logic       phase;
        logic       clamp;
        logic       res_wr;
        logic       res_commit;
        logic [1:0] ch;
        logic       emit;
        logic       any;
        logic       ovf;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       out_free;
    } t_sts;

    function automatic logic [15:0] load_q(input logic [15:0] x);
        return (x > 16'(ONE)) ? 16'(ONE) : x;
    endfunction

    function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [S_W-1:0] v);
        if (v > ACC_MAX)
            return ACC_BITS'(ACC_MAX);
        else if (v < -ACC_MAX)
            return ACC_BITS'(-ACC_MAX);
        else
            return ACC_BITS'(v);
    endfunction

    function automatic logic [15:0] clamp_unit(input logic signed [ACC_BITS-1:0] v);
        if (v < 0)
            return 16'd0;
        else if (v > ACC_BITS'(ONE))
            return 16'(ONE);
        else
            return v[15:0];
    endfunction

    function automatic logic two_phase(input logic [2:0] m);
        return (m == MODE_MULTIPLY) || (m == MODE_OVERLAY) ||
               (m == MODE_SCREEN) || (m == MODE_LINEAR);
    endfunction

endpackage

@@ hdl/layered_mask_blend_composer.sv @@
// Begin and add-layer words are taken back to back while idle.
// Compose word: per filtered channel, each blend stage reads all N stored layers,
//   one multiply per copy/add/subtract layer and two per two-multiply layer,
//   serialised on the single shared multiplier and the one-port layer memory.
// Result is held in an output register; new words are taken while it waits.
// Synchronous active-low reset clears control, colors and filters (filters to 1).
module layered_mask_blend_composer
    import lmbc_pkg::*;
#(
    parameter int MAX_LAYERS = DEF_MAX_LAYERS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic      i_cfg_data
);

    localparam int ADDR_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

    t_cmd              cmd;
    t_sts              sts;
    logic [ADDR_W-1:0] addr;

    lmbc_controller #(.MAX_LAYERS(MAX_LAYERS), .ADDR_W(ADDR_W)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_in_data.action),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_addr      (addr)
    );

    lmbc_datapath #(.MAX_LAYERS(MAX_LAYERS), .ADDR_W(ADDR_W)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_addr      (addr),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ hdl/lmbc_datapath.sv @@
module lmbc_datapath
    import lmbc_pkg::*;
#(
    parameter int MAX_LAYERS = DEF_MAX_LAYERS,
    parameter int ADDR_W     = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_word          i_in_data,
    input  t_cmd              i_cmd,
    input  logic [ADDR_W-1:0] i_addr,
    output t_sts              o_sts,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output t_out_word         o_out_data
);

    t_layer                      mem [MAX_LAYERS];
    t_layer                      r_rd;
    logic [15:0]                 r_base [4];
    logic [15:0]                 r_comm [3];
    logic [15:0]                 r_res [3];
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [T_W-1:0]       r_t;
    logic signed [P_W-1:0]       r_prod;
    logic                        r_out_valid;
    t_out_word                   r_out;

    logic signed [A_W-1:0] acc_a, v_a, t_a, one_a, op_a;
    logic signed [B_W-1:0] op_b, m_b, one_b, t_b, op2_b;
    logic                  low_half;
    logic                  neg;
    logic [P_W-1:0]        mag, mag_h;
    logic signed [S_W-1:0] pq, accs, one_s;
    logic signed [ACC_BITS-1:0] n_acc;
    logic signed [T_W-1:0]      n_t;
    logic                       wr_acc, wr_t;
    logic                       out_free;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_sts    = '{mode: r_rd.mode, out_free: out_free};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_addr] <= '{value:   load_q(i_in_data.mask_value),
                             opacity: load_q(i_in_data.layer_opacity),
                             mode:    i_in_data.blend_mode};
        end
        r_rd <= mem[i_addr];
    end

    assign acc_a = A_W'(r_acc);
    assign v_a   = $signed({{(A_W-16){1'b0}}, r_rd.value});
    assign t_a   = A_W'(r_t);
    assign one_a = A_W'(ONE);
    assign op_b  = $signed({{(B_W-16){1'b0}}, r_rd.opacity});
    assign m_b   = $signed({{(B_W-16){1'b0}}, r_rd.value});
    assign one_b = B_W'(ONE);
    assign t_b   = B_W'(r_t);
    assign low_half = r_acc < ACC_BITS'(HALF);

    // multiplier operands by mode and phase
    always_comb begin
        op_a  = '0;
        op2_b = '0;
        case (r_rd.mode)
            MODE_COPY: begin
                op_a = v_a - acc_a; op2_b = op_b;
            end
            MODE_ADD, MODE_SUBTRACT: begin
                op_a = v_a; op2_b = op_b;
            end
            MODE_MULTIPLY: begin
                if (!i_cmd.phase) begin
                    op_a = v_a - one_a; op2_b = op_b;
                end else begin
                    op_a = acc_a; op2_b = t_b;
                end
            end
            MODE_OVERLAY: begin
                if (i_cmd.phase) begin
                    op_a = t_a - acc_a; op2_b = op_b;
                end else if (low_half) begin
                    op_a = acc_a + acc_a; op2_b = m_b;
                end else begin
                    op_a = (one_a - acc_a) + (one_a - acc_a); op2_b = one_b - m_b;
                end
            end
            MODE_SCREEN: begin
                if (!i_cmd.phase) begin
                    op_a = v_a; op2_b = op_b;
                end else begin
                    op_a = one_a - acc_a; op2_b = t_b;
                end
            end
            MODE_LINEAR: begin
                if (!i_cmd.phase) begin
                    op_a = v_a - acc_a; op2_b = m_b;
                end else begin
                    op_a = t_a - acc_a; op2_b = op_b;
                end
            end
            default: begin
                op_a  = '0;
                op2_b = '0;
            end
        endcase
    end

    // round to nearest, ties away from zero
    assign neg   = r_prod[P_W-1];
    assign mag   = neg ? P_W'(-r_prod) : P_W'(r_prod);
    assign mag_h = mag + P_W'(HALF);
    assign pq    = neg ? -S_W'(mag_h[P_W-1:FRAC_BITS]) : S_W'(mag_h[P_W-1:FRAC_BITS]);
    assign accs  = S_W'(r_acc);
    assign one_s = S_W'(ONE);

    always_comb begin
        n_acc  = r_acc;
        n_t    = r_t;
        wr_acc = 1'b0;
        wr_t   = 1'b0;
        case (r_rd.mode)
            MODE_COPY, MODE_ADD: begin
                n_acc = sat_acc(accs + pq); wr_acc = 1'b1;
            end
            MODE_SUBTRACT: begin
                n_acc = sat_acc(accs - pq); wr_acc = 1'b1;
            end
            MODE_MULTIPLY: begin
                if (!i_cmd.phase) begin
                    n_t = T_W'(one_s + pq); wr_t = 1'b1;
                end else begin
                    n_acc = sat_acc(pq); wr_acc = 1'b1;
                end
            end
            MODE_OVERLAY: begin
                if (!i_cmd.phase) begin
                    n_t  = low_half ? T_W'(pq) : T_W'(one_s - pq);
                    wr_t = 1'b1;
                end else begin
                    n_acc = sat_acc(accs + pq); wr_acc = 1'b1;
                end
            end
            MODE_SCREEN: begin
                if (!i_cmd.phase) begin
                    n_t = T_W'(one_s - pq); wr_t = 1'b1;
                end else begin
                    n_acc = sat_acc(one_s - pq); wr_acc = 1'b1;
                end
            end
            MODE_LINEAR: begin
                if (!i_cmd.phase) begin
                    n_t = T_W'(sat_acc(accs + pq)); wr_t = 1'b1;
                end else begin
                    n_acc = sat_acc(accs + pq); wr_acc = 1'b1;
                end
            end
            default: begin
                wr_acc = 1'b0;
                wr_t   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '{default: '0};
            r_comm <= '{default: '0};
            r_acc  <= '0;
        end else begin
            if (i_cmd.load_vertex) begin
                r_base[0] <= load_q(i_in_data.base_red);
                r_base[1] <= load_q(i_in_data.base_green);
                r_base[2] <= load_q(i_in_data.base_blue);
                r_base[3] <= load_q(i_in_data.base_alpha);
                r_comm[0] <= load_q(i_in_data.committed_red);
                r_comm[1] <= load_q(i_in_data.committed_green);
                r_comm[2] <= load_q(i_in_data.committed_blue);
            end
            if (i_cmd.init_acc)
                r_acc <= ACC_BITS'(r_base[i_cmd.ch]);
            else if (i_cmd.clamp)
                r_acc <= ACC_BITS'(clamp_unit(r_acc));
            else if (i_cmd.upd_en && wr_acc)
                r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en)
            r_prod <= op_a * op2_b;
        if (i_cmd.upd_en && wr_t)
            r_t <= n_t;
        if (i_cmd.res_wr)
            r_res[i_cmd.ch] <= i_cmd.res_commit ? r_comm[i_cmd.ch] : clamp_unit(r_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && out_free) begin
            r_out <= '{out_red:   r_res[0],
                       out_green: r_res[1],
                       out_blue:  r_res[2],
                       out_alpha: r_base[3],
                       any_contributed: i_cmd.any,
                       status:    i_cmd.ovf};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hdl/lmbc_controller.sv @@
module lmbc_controller
    import lmbc_pkg::*;
#(
    parameter int MAX_LAYERS = DEF_MAX_LAYERS,
    parameter int ADDR_W     = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_action,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic              i_cfg_data,
    input  t_sts              i_sts,
    output t_cmd              o_cmd,
    output logic [ADDR_W-1:0] o_addr
);

    localparam int CNT_W = $clog2(MAX_LAYERS + 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_ovf, n_ovf;
    logic [1:0]         r_ch, n_ch;
    logic [2:0]         r_stage, n_stage;
    logic [2:0]         r_filt;
    logic               accept;
    logic               match;
    logic               last_idx;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign last_idx = CNT_W'(r_idx + 1'b1) >= r_count;

    // stage order: copy, add/subtract, multiply, overlay, screen, linear
    always_comb begin
        unique case (r_stage)
            3'd0:    match = i_sts.mode == MODE_COPY;
            3'd1:    match = (i_sts.mode == MODE_ADD) || (i_sts.mode == MODE_SUBTRACT);
            3'd2:    match = i_sts.mode == MODE_MULTIPLY;
            3'd3:    match = i_sts.mode == MODE_OVERLAY;
            3'd4:    match = i_sts.mode == MODE_SCREEN;
            3'd5:    match = i_sts.mode == MODE_LINEAR;
            default: match = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
            r_ch    <= '0;
            r_stage <= '0;
            r_filt  <= 3'b111;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
            r_ch    <= n_ch;
            r_stage <= n_stage;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FILTER_RED:   r_filt[0] <= i_cfg_data;
                    CFG_FILTER_GREEN: r_filt[1] <= i_cfg_data;
                    CFG_FILTER_BLUE:  r_filt[2] <= i_cfg_data;
                    default:          r_filt    <= r_filt;
                endcase
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_ovf   = r_ovf;
        n_ch    = r_ch;
        n_stage = r_stage;
        o_cmd   = '0;
        o_cmd.ch    = r_ch;
        o_cmd.any   = r_count != '0;
        o_cmd.ovf   = r_ovf;
        o_addr  = (r_state == ST_IDLE) ? r_count[ADDR_W-1:0] : r_idx[ADDR_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_BEGIN: begin
                            o_cmd.load_vertex = 1'b1;
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        ACT_ADD: begin
                            if (r_count < CNT_W'(MAX_LAYERS)) begin
                                o_cmd.wr_en = 1'b1;
                                n_count = CNT_W'(r_count + 1'b1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        ACT_COMPOSE: begin
                            n_ch    = '0;
                            n_state = ST_CHAN;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CHAN: begin
                if (r_count == '0 || !r_filt[r_ch]) begin
                    o_cmd.res_wr     = 1'b1;
                    o_cmd.res_commit = 1'b1;
                    if (r_ch == 2'd2) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_ch = r_ch + 2'd1;
                    end
                end else begin
                    o_cmd.init_acc = 1'b1;
                    n_stage = '0;
                    n_idx   = '0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (match) begin
                    n_state = ST_MUL0;
                end else if (last_idx) begin
                    n_state = ST_STAGE_END;
                end else begin
                    n_idx   = CNT_W'(r_idx + 1'b1);
                    n_state = ST_READ;
                end
            end
            ST_MUL0: begin
                o_cmd.mul_en = 1'b1;
                n_state = ST_UPD0;
            end
            ST_UPD0: begin
                o_cmd.upd_en = 1'b1;
                if (two_phase(i_sts.mode)) begin
                    n_state = ST_MUL1;
                end else if (last_idx) begin
                    n_state = ST_STAGE_END;
                end else begin
                    n_idx   = CNT_W'(r_idx + 1'b1);
                    n_state = ST_READ;
                end
            end
            ST_MUL1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.phase  = 1'b1;
                n_state = ST_UPD1;
            end
            ST_UPD1: begin
                o_cmd.upd_en = 1'b1;
                o_cmd.phase  = 1'b1;
                if (last_idx) begin
                    n_state = ST_STAGE_END;
                end else begin
                    n_idx   = CNT_W'(r_idx + 1'b1);
                    n_state = ST_READ;
                end
            end
            ST_STAGE_END: begin
                if (r_stage == 3'd5) begin
                    o_cmd.res_wr = 1'b1;
                    if (r_ch == 2'd2) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_ch    = r_ch + 2'd1;
                        n_state = ST_CHAN;
                    end
                end else begin
                    // unit clamp sits between multiply and overlay
                    o_cmd.clamp = r_stage == 3'd2;
                    n_stage = r_stage + 3'd1;
                    n_idx   = '0;
                    n_state = ST_READ;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.out_free)
                    n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = r_state != ST_IDLE;

endmodule

@@ hdl/lmbc_checker.sv @@
module lmbc_checker
    import lmbc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result word changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.out_red <= 16'(ONE) && o_out_data.out_green <= 16'(ONE)
                        && o_out_data.out_blue <= 16'(ONE) && o_out_data.out_alpha <= 16'(ONE))
        else $error("result channel above one");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && i_in_data.action == ACT_COMPOSE))
        else $error("busy without a compose word");

endmodule

bind layered_mask_blend_composer lmbc_checker u_lmbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ sim/tb_layered_mask_blend_composer.sv @@
module tb_layered_mask_blend_composer;
    import lmbc_pkg::*;

    localparam int LAYER_CAP   = 16;
    localparam int WATCH_LIMIT = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_data;
    logic      i_cfg_we;
    logic [1:0] i_cfg_index;
    logic      i_cfg_data;

    layered_mask_blend_composer dut (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // predictor state
    longint base_c[4];
    longint comm_c[3];
    longint lay_val[LAYER_CAP];
    longint lay_opa[LAYER_CAP];
    int     lay_mode[LAYER_CAP];
    int     lay_cnt;
    bit     ovf;
    bit     filt[3];

    t_in_word  pending_words[$];
    t_out_word expected_colors[$];
    int errors;
    int idle_cycles;
    bit in_taken;

    localparam longint ONE_L = longint'(ONE);
    localparam longint AMAX  = (longint'(1) <<< (ACC_BITS - 1)) - 1;

    function automatic longint ld(logic [15:0] x);
        return (x > 16'(ONE)) ? ONE_L : longint'(x);
    endfunction

    function automatic longint sat(longint v);
        if (v > AMAX) return AMAX;
        if (v < -AMAX) return -AMAX;
        return v;
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v < 0) return 0;
        if (v > ONE_L) return ONE_L;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        longint m;
        p = a * b;
        m = ((p < 0 ? -p : p) + longint'(HALF)) >>> FRAC_BITS;
        return (p < 0) ? -m : m;
    endfunction

    function automatic longint lerp(longint a, longint b, longint t);
        return sat(a + qmul(b - a, t));
    endfunction

    function automatic longint blend_channel(longint base);
        longint r;
        longint b;
        longint k;
        r = base;
        for (int i = 0; i < lay_cnt; i++)
            if (lay_mode[i] == MODE_COPY) r = lerp(r, lay_val[i], lay_opa[i]);
        for (int i = 0; i < lay_cnt; i++) begin
            k = qmul(lay_val[i], lay_opa[i]);
            if (lay_mode[i] == MODE_ADD) r = sat(r + k);
            else if (lay_mode[i] == MODE_SUBTRACT) r = sat(r - k);
        end
        for (int i = 0; i < lay_cnt; i++)
            if (lay_mode[i] == MODE_MULTIPLY)
                r = sat(qmul(r, ONE_L + qmul(lay_val[i] - ONE_L, lay_opa[i])));
        r = unit_clamp(r);
        for (int i = 0; i < lay_cnt; i++)
            if (lay_mode[i] == MODE_OVERLAY) begin
                if (r < ONE_L / 2) b = qmul(2 * r, lay_val[i]);
                else b = ONE_L - qmul(2 * (ONE_L - r), ONE_L - lay_val[i]);
                r = lerp(r, b, lay_opa[i]);
            end
        for (int i = 0; i < lay_cnt; i++)
            if (lay_mode[i] == MODE_SCREEN) begin
                k = ONE_L - qmul(lay_val[i], lay_opa[i]);
                r = sat(ONE_L - qmul(ONE_L - r, k));
            end
        for (int i = 0; i < lay_cnt; i++)
            if (lay_mode[i] == MODE_LINEAR) begin
                b = lerp(r, lay_val[i], lay_val[i]);
                r = lerp(r, b, lay_opa[i]);
            end
        return unit_clamp(r);
    endfunction

    task automatic predict_word(t_in_word w);
        t_out_word o;
        longint ch[3];
        case (w.action)
            ACT_BEGIN: begin
                base_c[0] = ld(w.base_red);
                base_c[1] = ld(w.base_green);
                base_c[2] = ld(w.base_blue);
                base_c[3] = ld(w.base_alpha);
                comm_c[0] = ld(w.committed_red);
                comm_c[1] = ld(w.committed_green);
                comm_c[2] = ld(w.committed_blue);
                lay_cnt = 0;
                ovf = 0;
            end
            ACT_ADD: begin
                if (lay_cnt < LAYER_CAP) begin
                    lay_val[lay_cnt] = ld(w.mask_value);
                    lay_opa[lay_cnt] = ld(w.layer_opacity);
                    lay_mode[lay_cnt] = int'(w.blend_mode);
                    lay_cnt++;
                end else begin
                    ovf = 1;
                end
            end
            ACT_COMPOSE: begin
                for (int c = 0; c < 3; c++)
                    ch[c] = (lay_cnt == 0 || !filt[c]) ? comm_c[c] : blend_channel(base_c[c]);
                o.out_red = 16'(ch[0]);
                o.out_green = 16'(ch[1]);
                o.out_blue = 16'(ch[2]);
                o.out_alpha = 16'(base_c[3]);
                o.any_contributed = (lay_cnt != 0);
                o.status = ovf;
                expected_colors.push_back(o);
            end
            default: ;
        endcase
    endtask

    // driver: bursts and gaps
    int gap_left;
    int burst_left;
    bit hold_off;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // in_taken is the handshake seen at the last rising edge
            if (in_taken) void'(pending_words.pop_front());
            if (!i_in_valid || in_taken) begin
                if (hold_off || pending_words.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_words[0];
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 7) < 3) && ($time % 3000 > 800);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken = i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) predict_word(i_in_data);
            if (o_out_valid && !i_out_stall) begin
                if (expected_colors.size() == 0) begin
                    errors++;
                    $display("%0t unexpected word: actual %h", $time, o_out_data);
                end else begin
                    t_out_word e;
                    e = expected_colors.pop_front();
                    if (e !== o_out_data) begin
                        errors++;
                        $display("%0t mismatch: expected %h actual %h", $time, e, o_out_data);
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else if (!hold_off || expected_colors.size() != 0)
                idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic t_in_word mk(t_action a, logic [15:0] v, logic [15:0] o, logic [2:0] m);
        t_in_word w;
        w = '0;
        w.action = a;
        w.mask_value = v;
        w.layer_opacity = o;
        w.blend_mode = m;
        return w;
    endfunction

    function automatic logic [15:0] rnd_q();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'(ONE);
            2: return 16'($urandom);
            3: return 16'(ONE / 2 + $urandom_range(0, 2) - 1);
            default: return 16'($urandom_range(0, ONE));
        endcase
    endfunction

    function automatic t_in_word rnd_begin();
        t_in_word w;
        w = '0;
        w.action = ACT_BEGIN;
        w.base_red = rnd_q();
        w.base_green = rnd_q();
        w.base_blue = rnd_q();
        w.base_alpha = rnd_q();
        w.committed_red = rnd_q();
        w.committed_green = rnd_q();
        w.committed_blue = rnd_q();
        w.mask_value = 16'($urandom);
        w.layer_opacity = 16'($urandom);
        w.blend_mode = 3'($urandom);
        return w;
    endfunction

    function automatic t_in_word rnd_layer();
        t_in_word w;
        w = rnd_begin();
        w.action = ACT_ADD;
        w.mask_value = rnd_q();
        w.layer_opacity = rnd_q();
        w.blend_mode = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        return w;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
    endtask

    task automatic set_filters(bit r, bit g, bit b);
        bit v[3];
        v = '{r, g, b};
        for (int i = 0; i < 3; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= t_cfg_index'(i);
            i_cfg_data <= v[i];
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
            filt[i] = v[i];
        end
    endtask

    int n_items;
    int n_lay;
    t_in_word w;

    initial begin
        errors = 0;
        idle_cycles = 0;
        in_taken = 1'b0;
        gap_left = 0;
        burst_left = 0;
        hold_off = 1'b0;
        lay_cnt = 0;
        ovf = 0;
        foreach (base_c[i]) base_c[i] = 0;
        foreach (comm_c[i]) comm_c[i] = 0;
        filt = '{1, 1, 1};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_FILTER_RED;
        i_cfg_data = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: compose before any begin, then every mode, overflow, action three
        pending_words.push_back(mk(ACT_COMPOSE, '0, '0, '0));
        w = rnd_begin();
        w.base_red = 16'hFFFF; w.base_green = '0; w.base_blue = 16'(ONE / 2);
        w.base_alpha = 16'hFFFF; w.committed_red = 16'hFFFF;
        pending_words.push_back(w);
        pending_words.push_back(mk(ACT_COMPOSE, '0, '0, '0));
        for (int m = 0; m < 8; m++)
            pending_words.push_back(mk(ACT_ADD, (m % 2) ? 16'hFFFF : 16'(ONE / 3),
                                       (m < 4) ? 16'(ONE) : 16'h8001, 3'(m)));
        pending_words.push_back(mk(ACT_COMPOSE, '0, '0, '0));
        for (int i = 0; i < 9; i++)
            pending_words.push_back(mk(ACT_ADD, 16'(ONE), 16'(ONE), MODE_ADD));
        pending_words.push_back(mk(t_action'(3), '0, '0, '0));
        pending_words.push_back(mk(ACT_COMPOSE, '0, '0, '0));
        pending_words.push_back(mk(ACT_COMPOSE, '0, '0, '0));
        wait_drained();

        n_items = 0;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_filters(0, 0, 0);
                1: set_filters(1, 0, 1);
                2: set_filters(0, 1, 0);
                3: set_filters(1, 1, 1);
                default: set_filters(1, 1, 0);
            endcase
            while (n_items < (phase + 1) * 320) begin
                if ($urandom_range(0, 19) == 0) begin
                    w = rnd_layer();
                    w.action = t_action'($urandom_range(0, 3));
                    pending_words.push_back(w);
                    n_items++;
                    continue;
                end
                pending_words.push_back(rnd_begin());
                n_lay = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19)
                                                    : $urandom_range(0, 5);
                for (int i = 0; i < n_lay; i++) pending_words.push_back(rnd_layer());
                pending_words.push_back(mk(ACT_COMPOSE, '0, '0, '0));
                if ($urandom_range(0, 5) == 0)
                    pending_words.push_back(mk(ACT_COMPOSE, '0, '0, '0));
                n_items += n_lay + 2;
                if ($urandom_range(0, 40) == 0) begin
                    hold_off = 1'b1;
                    while (pending_words.size() != 0 && !(i_in_valid && o_in_stall)) begin
                        if (expected_colors.size() == 0) break;
                        @(posedge i_clk);
                    end
                    while (expected_colors.size() != 0) @(posedge i_clk);
                    hold_off = 1'b0;
                end
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ layered_mask_blend_composer.f @@
hdl/lmbc_pkg.sv
hdl/lmbc_datapath.sv
hdl/lmbc_controller.sv
hdl/layered_mask_blend_composer.sv
hdl/lmbc_checker.sv
sim/tb_layered_mask_blend_composer.sv
